// ===== src/cst_pkg.sv =====
package cst_pkg;

    localparam int OP_W       = 2;
    localparam int HOST_W     = 64;
    localparam int PORT_W     = 16;
    localparam int TIME_W     = 64;
    localparam int SLOT_W     = 5;
    localparam int HEALTH_W   = 7;
    localparam int MODE_W     = 2;
    localparam int LIMIT_W    = 31;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 6;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_REAP    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

    localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUSY      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNHEALTHY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WARMING   = 2'd3;

    localparam logic [LIMIT_W-1:0]  LIMIT_DEFAULT = 31'd300000;
    localparam logic [HEALTH_W-1:0] HEALTH_START  = 7'd100;
    localparam logic [HEALTH_W-1:0] HEALTH_STEP   = 7'd20;

    typedef struct packed {
        logic [HOST_W-1:0]   host;
        logic [PORT_W-1:0]   port;
        logic [MODE_W-1:0]   mode;
        logic [HEALTH_W-1:0] health;
        logic [TIME_W-1:0]   stamp;
    } slot_entry_t;

    typedef struct packed {
        logic take;
        logic expire;
    } slot_eval_t;

endpackage

// ===== src/cst_slot_mem.sv =====
module cst_slot_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        wa,
    input  cst_pkg::slot_entry_t wd,
    input  logic [AW-1:0]        ra,
    output cst_pkg::slot_entry_t rd
);

    cst_pkg::slot_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule

// ===== src/cst_unit.sv =====
module cst_unit (
    input  logic                                 is_reap,
    input  cst_pkg::slot_entry_t                 entry,
    input  logic [cst_pkg::HOST_W-1:0]           host,
    input  logic [cst_pkg::PORT_W-1:0]           port,
    input  logic [cst_pkg::TIME_W-1:0]           now,
    input  logic [cst_pkg::LIMIT_W-1:0]          limit,
    input  logic                                 found,
    input  logic [cst_pkg::HEALTH_W-1:0]         best_health,
    output cst_pkg::slot_eval_t                  result
);

    logic [cst_pkg::TIME_W-1:0] age;
    logic                       match;
    logic                       waiting;

    always_comb
    begin
        // age wraps modulo 2^64
        age     = now - entry.stamp;
        match   = (entry.mode == cst_pkg::MODE_IDLE) && (entry.host == host) &&
                  (entry.port == port);
        waiting = (entry.mode == cst_pkg::MODE_IDLE) ||
                  (entry.mode == cst_pkg::MODE_UNHEALTHY);
        result.take   = !is_reap && match && (!found || entry.health > best_health);
        result.expire = is_reap && waiting && (age > cst_pkg::TIME_W'(limit));
    end

endmodule

// ===== src/connection_slot_table_top.sv =====
// acquire and reap walk the table reading one slot per cycle; the result is valid
// after the walk, when the response state registers it (an empty table reads no slot)
// release passes through read, modify and write back, result; an unused operation or a
// release outside the table goes straight to result; the next item is accepted after it
// one item at a time; a result waiting at the output only holds back the next result
// reset clears table size, busy count and handshake, idle limit 300000; slot memory kept
module connection_slot_table_top #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // host_key[63:0], port[79:64], now_ms[143:80], slot_index[148:144], healthy[149]
    input  logic [cst_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation[1:0]
    input  logic [cst_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status[1:0], slot[6:2], reaped_count[12:7], busy_count[18:13], table_size[24:19]
    output logic [cst_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cst_pkg::LIMIT_W-1:0]        cfg_data
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_REL  = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [cst_pkg::OP_W-1:0]        op_reg, op_next;
    logic [cst_pkg::HOST_W-1:0]      host_reg, host_next;
    logic [cst_pkg::PORT_W-1:0]      port_reg, port_next;
    logic [cst_pkg::TIME_W-1:0]      now_reg, now_next;
    logic [cst_pkg::SLOT_W-1:0]      sidx_reg, sidx_next;
    logic                            healthy_reg, healthy_next;
    logic [CNT_W-1:0]                used_reg, used_next;
    logic [CNT_W-1:0]                busy_reg, busy_next;
    logic [CNT_W-1:0]                issue_reg, issue_next;
    logic                            pend_reg, pend_next;
    logic [IDX_W-1:0]                eval_idx_reg, eval_idx_next;
    logic [CNT_W-1:0]                keep_reg, keep_next;
    logic [CNT_W-1:0]                reaped_reg, reaped_next;
    logic                            found_reg, found_next;
    logic [IDX_W-1:0]                best_reg, best_next;
    logic [cst_pkg::HEALTH_W-1:0]    best_health_reg, best_health_next;
    logic [cst_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [cst_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [cst_pkg::LIMIT_W-1:0]     limit_reg, limit_next;
    logic                            out_valid_reg, out_valid_next;
    logic [cst_pkg::OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic                            mem_we;
    logic [IDX_W-1:0]                mem_wa;
    cst_pkg::slot_entry_t            mem_wd;
    logic [IDX_W-1:0]                mem_ra;
    cst_pkg::slot_entry_t            mem_rd;
    cst_pkg::slot_eval_t             ev;

    logic [cst_pkg::SLOT_W-1:0]      sidx_in;
    logic                            issue_more;
    cst_pkg::slot_entry_t            rel_entry;

    cst_slot_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (IDX_W)
    ) u_mem (
        .clk (clk),
        .we  (mem_we),
        .wa  (mem_wa),
        .wd  (mem_wd),
        .ra  (mem_ra),
        .rd  (mem_rd)
    );

    cst_unit u_unit (
        .is_reap     (op_reg == cst_pkg::OP_REAP),
        .entry       (mem_rd),
        .host        (host_reg),
        .port        (port_reg),
        .now         (now_reg),
        .limit       (limit_reg),
        .found       (found_reg),
        .best_health (best_health_reg),
        .result      (ev)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;
    assign sidx_in       = s_axis_tdata[148:144];
    assign issue_more    = (issue_reg < used_reg);
    assign mem_ra        = (state_reg == ST_SCAN) ? issue_reg[IDX_W-1:0] : IDX_W'(sidx_reg);

    always_comb
    begin
        rel_entry = mem_rd;
        if (healthy_reg)
        begin
            rel_entry.mode = cst_pkg::MODE_IDLE;
        end
        else
        begin
            rel_entry.mode   = cst_pkg::MODE_UNHEALTHY;
            rel_entry.health = (mem_rd.health > cst_pkg::HEALTH_STEP) ?
                               mem_rd.health - cst_pkg::HEALTH_STEP : '0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        host_next        = host_reg;
        port_next        = port_reg;
        now_next         = now_reg;
        sidx_next        = sidx_reg;
        healthy_next     = healthy_reg;
        used_next        = used_reg;
        busy_next        = busy_reg;
        issue_next       = issue_reg;
        pend_next        = pend_reg;
        eval_idx_next    = eval_idx_reg;
        keep_next        = keep_reg;
        reaped_next      = reaped_reg;
        found_next       = found_reg;
        best_next        = best_reg;
        best_health_next = best_health_reg;
        status_next      = status_reg;
        slot_next        = slot_reg;
        limit_next       = limit_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        mem_we           = 1'b0;
        mem_wa           = '0;
        mem_wd           = mem_rd;

        if (cfg_valid)
        begin
            limit_next = (cfg_data == '0) ? cst_pkg::LIMIT_DEFAULT : cfg_data;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next          = s_axis_tuser;
                    host_next        = s_axis_tdata[63:0];
                    port_next        = s_axis_tdata[79:64];
                    now_next         = s_axis_tdata[143:80];
                    sidx_next        = sidx_in;
                    healthy_next     = s_axis_tdata[149];
                    status_next      = cst_pkg::STATUS_OK;
                    slot_next        = '0;
                    reaped_next      = '0;
                    keep_next        = '0;
                    issue_next       = '0;
                    pend_next        = 1'b0;
                    found_next       = 1'b0;
                    best_next        = '0;
                    best_health_next = '0;
                    unique case (s_axis_tuser)
                        cst_pkg::OP_ACQUIRE, cst_pkg::OP_REAP:
                        begin
                            state_next = ST_SCAN;
                        end
                        cst_pkg::OP_RELEASE:
                        begin
                            if (32'(sidx_in) < 32'(used_reg))
                            begin
                                state_next = ST_RD;
                            end
                            else
                            begin
                                status_next = cst_pkg::STATUS_NOT_USED;
                                state_next  = ST_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // read slot issue_reg while the unit judges the slot read last cycle
                if (issue_more)
                begin
                    issue_next    = issue_reg + 1'b1;
                    eval_idx_next = issue_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (op_reg == cst_pkg::OP_REAP)
                    begin
                        if (ev.expire)
                        begin
                            reaped_next = reaped_reg + 1'b1;
                        end
                        else
                        begin
                            // compaction: keep never passes the slot being read
                            mem_we    = 1'b1;
                            mem_wa    = keep_reg[IDX_W-1:0];
                            mem_wd    = mem_rd;
                            keep_next = keep_reg + 1'b1;
                        end
                    end
                    else if (ev.take)
                    begin
                        found_next       = 1'b1;
                        best_next        = eval_idx_reg;
                        best_health_next = mem_rd.health;
                    end
                end

                if (!issue_more && !pend_reg)
                begin
                    state_next = ST_RESP;
                    if (op_reg == cst_pkg::OP_REAP)
                    begin
                        used_next = keep_reg;
                    end
                    else if (found_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_wa    = best_reg;
                        mem_wd    = '{host: host_reg, port: port_reg,
                                      mode: cst_pkg::MODE_BUSY,
                                      health: best_health_reg, stamp: now_reg};
                        busy_next = busy_reg + 1'b1;
                        slot_next = cst_pkg::SLOT_W'(best_reg);
                    end
                    else if (used_reg >= CNT_W'(SLOT_COUNT))
                    begin
                        status_next = cst_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wa    = used_reg[IDX_W-1:0];
                        mem_wd    = '{host: host_reg, port: port_reg,
                                      mode: cst_pkg::MODE_WARMING,
                                      health: cst_pkg::HEALTH_START, stamp: now_reg};
                        slot_next = cst_pkg::SLOT_W'(used_reg);
                        used_next = used_reg + 1'b1;
                    end
                end
            end

            ST_RD:
            begin
                state_next = ST_REL;
            end

            ST_REL:
            begin
                mem_we = 1'b1;
                mem_wa = IDX_W'(sidx_reg);
                mem_wd = rel_entry;
                if (mem_rd.mode == cst_pkg::MODE_BUSY)
                begin
                    busy_next = busy_reg - 1'b1;
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'b0,
                                      cst_pkg::CNT_OUT_W'(used_reg),
                                      cst_pkg::CNT_OUT_W'(busy_reg),
                                      cst_pkg::CNT_OUT_W'(reaped_reg),
                                      slot_reg,
                                      status_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            busy_reg      <= '0;
            pend_reg      <= 1'b0;
            limit_reg     <= cst_pkg::LIMIT_DEFAULT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        host_reg        <= host_next;
        port_reg        <= port_next;
        now_reg         <= now_next;
        sidx_reg        <= sidx_next;
        healthy_reg     <= healthy_next;
        issue_reg       <= issue_next;
        eval_idx_reg    <= eval_idx_next;
        keep_reg        <= keep_next;
        reaped_reg      <= reaped_next;
        found_reg       <= found_next;
        best_reg        <= best_next;
        best_health_reg <= best_health_next;
        status_reg      <= status_next;
        slot_reg        <= slot_next;
        out_data_reg    <= out_data_next;
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(SLOT_COUNT))
        else $error("table size above slot count");

    a_busy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg <= used_reg)
        else $error("busy count above table size");

    a_reap_account: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && op_reg == cst_pkg::OP_REAP) |->
        (SUM_W'(keep_reg) + SUM_W'(reaped_reg) + SUM_W'(pend_reg) == SUM_W'(issue_reg)))
        else $error("reap walk lost track of a slot");

    a_release_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REL) |-> (32'(sidx_reg) < 32'(used_reg)))
        else $error("release writes a slot outside the table");

endmodule
